### src/rpwm_pkg.sv
package rpwm_pkg;

   localparam int ROWS      = 2048;
   localparam int ROW_AW    = $clog2(ROWS);
   localparam int ROW_CW    = ROW_AW + 1;
   localparam int CNT_W     = 13;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int CSR_IW     = 3;
   localparam int CSR_DW     = 16;
   localparam int NUM_W      = 30;
   localparam int DIV_NW     = 31;
   localparam int DIV_DW     = 15;

   typedef enum logic [CSR_IW-1:0] {
      CSR_SLOPE  = 3'd0,
      CSR_MARGIN = 3'd1,
      CSR_SEARCH = 3'd2,
      CSR_REFOFS = 3'd3,
      CSR_SPAN   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_START = 2'd1,
      STATUS_ZERO_REF = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_S_RD,
      ST_S_CHK,
      ST_M_RD,
      ST_M_CHK,
      ST_R_RD,
      ST_R_CHK,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             frame_end;
   } row_rec_type;

   typedef struct packed {
      logic        push;
      row_rec_type rec;
   } fifo_wr_type;

endpackage

### src/rpwm_if.sv
interface rpwm_req_if;
   logic valid;
   logic ready;
   logic foreground;
   logic row_end;
   logic frame_end;
   modport source (output valid, foreground, row_end, frame_end, input ready);
   modport sink (input valid, foreground, row_end, frame_end, output ready);
endinterface

interface rpwm_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] width_tenths;
   logic [10:0] start_row;
   logic [10:0] widest_row;
   logic [1:0]  status;
   modport source (output valid, width_tenths, start_row, widest_row, status, input ready);
   modport sink (input valid, width_tenths, start_row, widest_row, status, output ready);
endinterface

interface rpwm_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### src/rpwm_front.sv
module rpwm_front (
   input  logic               clock,
   input  logic               reset,
   rpwm_req_if.sink           req_chan,
   input  logic               fifo_full,
   output rpwm_pkg::fifo_wr_type fifo_wr
);

   logic [rpwm_pkg::CNT_W-1:0] count_ff, count_in, count_inc;
   logic                       accept;

   assign req_chan.ready = !fifo_full;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      count_inc = count_ff;
      if (req_chan.foreground && count_ff != rpwm_pkg::CNT_MAX) begin
         count_inc = count_ff + 1'b1;
      end
      count_in = count_ff;
      fifo_wr.push = 1'b0;
      fifo_wr.rec.count = count_inc;
      fifo_wr.rec.frame_end = req_chan.frame_end;
      if (accept) begin
         count_in = count_inc;
         // close the row on either end marker
         if (req_chan.row_end || req_chan.frame_end) begin
            fifo_wr.push = 1'b1;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### src/rpwm_fifo.sv
module rpwm_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  rpwm_pkg::fifo_wr_type  fifo_wr,
   input  logic                   pop,
   output rpwm_pkg::row_rec_type  rd_rec,
   output logic                   full,
   output logic                   empty
);

   rpwm_pkg::row_rec_type slot_ff [rpwm_pkg::FIFO_DEPTH];
   logic [rpwm_pkg::FIFO_AW:0] wr_ptr_ff, rd_ptr_ff;

   assign empty  = wr_ptr_ff == rd_ptr_ff;
   assign full   = (wr_ptr_ff[rpwm_pkg::FIFO_AW] != rd_ptr_ff[rpwm_pkg::FIFO_AW]) &&
                   (wr_ptr_ff[rpwm_pkg::FIFO_AW-1:0] == rd_ptr_ff[rpwm_pkg::FIFO_AW-1:0]);
   assign rd_rec = slot_ff[rd_ptr_ff[rpwm_pkg::FIFO_AW-1:0]];

   always_ff @(posedge clock) begin
      if (fifo_wr.push && !full) begin
         slot_ff[wr_ptr_ff[rpwm_pkg::FIFO_AW-1:0]] <= fifo_wr.rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (fifo_wr.push && !full) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop && !empty) rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

endmodule

### src/rpwm_div.sv
module rpwm_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [rpwm_pkg::DIV_NW-1:0] dividend,
   input  logic [rpwm_pkg::DIV_DW-1:0] divisor,
   output logic                        done,
   output logic [rpwm_pkg::DIV_NW-1:0] quotient
);

   logic                          busy_ff, busy_in, done_ff, done_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic [rpwm_pkg::DIV_DW-2:0]   rem_ff, rem_in;
   logic [rpwm_pkg::DIV_NW-1:0]   quo_ff, quo_in;
   logic [rpwm_pkg::DIV_DW-1:0]   den_ff, den_in, trial, sub;

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign trial    = {rem_ff, quo_ff[rpwm_pkg::DIV_NW-1]};
   assign sub      = trial - den_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = 5'(rpwm_pkg::DIV_NW - 1);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         if (trial >= den_ff) begin
            rem_in = sub[rpwm_pkg::DIV_DW-2:0];
            quo_in = {quo_ff[rpwm_pkg::DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = trial[rpwm_pkg::DIV_DW-2:0];
            quo_in = {quo_ff[rpwm_pkg::DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

### src/rpwm_back.sv
module rpwm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rpwm_pkg::row_rec_type rd_rec,
   input  logic                  fifo_empty,
   output logic                  pop,
   rpwm_rsp_if.source            rsp_chan,
   rpwm_csr_if.sink              csr_chan
);

   localparam int AW = rpwm_pkg::ROW_AW;
   localparam int CW = rpwm_pkg::ROW_CW;
   localparam int NW = rpwm_pkg::CNT_W;

   rpwm_pkg::back_state_type state_ff, state_in;

   // configuration
   logic signed [10:0] thr_ff;
   logic [7:0]         margin_ff;
   logic [11:0]        search_ff;
   logic [5:0]         refofs_ff;
   logic [15:0]        span_ff;

   logic [NW-1:0] prof_mem [rpwm_pkg::ROWS];
   logic [NW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          mem_we;

   logic [CW-1:0] row_idx_ff, row_idx_in, h_ff, h_in;
   logic [AW-1:0] k_ff, k_in, start_ff, start_in, widest_ff, widest_in;
   logic [NW-1:0] win_ff [4];
   logic [NW-1:0] win_in [4];
   logic [NW-1:0] min_ff, min_in, ref_ff, ref_in;
   logic [CW:0]   end_ff, end_in;
   logic signed [NW:0] diff_ff, diff_in;
   logic signed [rpwm_pkg::NUM_W-1:0] num_ff, num_in;
   logic [rpwm_pkg::NUM_W-1:0] num_abs;
   logic          neg_ff, neg_in;

   logic signed [15:0] res_width_ff, res_width_in;
   logic [10:0]   res_start_ff, res_start_in, res_widest_ff, res_widest_in;
   logic [1:0]    res_status_ff, res_status_in;

   logic [7:0]    m_eff;
   logic signed [NW+1:0] d4;
   logic          j_ok, found, k_last;
   logic [CW:0]   k_ext;

   logic                        div_go, div_done;
   logic [rpwm_pkg::DIV_NW-1:0] div_quo;
   logic [rpwm_pkg::DIV_NW-1:0] div_num;
   logic [rpwm_pkg::DIV_DW-1:0] div_den;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= -11'sd8;
         margin_ff <= 8'd10;
         search_ff <= 12'd200;
         refofs_ff <= 6'd5;
         span_ff   <= 16'd2159;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            rpwm_pkg::CSR_SLOPE:  thr_ff    <= $signed(csr_chan.data[10:0]);
            rpwm_pkg::CSR_MARGIN: margin_ff <= csr_chan.data[7:0];
            rpwm_pkg::CSR_SEARCH: search_ff <= csr_chan.data[11:0];
            rpwm_pkg::CSR_REFOFS: refofs_ff <= csr_chan.data[5:0];
            rpwm_pkg::CSR_SPAN:   span_ff   <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // profile store
   always_ff @(posedge clock) begin
      if (mem_we) prof_mem[row_idx_ff[AW-1:0]] <= rd_rec.count;
      rd_data_ff <= prof_mem[rd_addr];
   end

   assign rd_addr = k_ff;
   assign m_eff   = (margin_ff < 8'd2) ? 8'd2 : margin_ff;
   assign k_ext   = {2'b0, k_ff};
   // window holds rows k-1 .. k-4, read data is row k, center is k-2
   assign d4 = $signed({2'b0, win_ff[0]}) + $signed({2'b0, rd_data_ff})
             - $signed({2'b0, win_ff[2]}) - $signed({2'b0, win_ff[3]});
   assign j_ok = (k_ext >= ({5'b0, m_eff} + 13'd2)) &&
                 ((k_ext + {5'b0, m_eff}) < ({1'b0, h_ff} + 13'd2));
   assign found  = j_ok && (d4 < (NW+2)'(thr_ff));
   assign k_last = ({1'b0, k_ff} + 12'd1) >= h_ff;

   assign num_abs = num_ff[rpwm_pkg::NUM_W-1] ? rpwm_pkg::NUM_W'(-num_ff)
                                               : rpwm_pkg::NUM_W'(num_ff);
   assign div_num = {num_abs, 1'b0} + rpwm_pkg::DIV_NW'(ref_ff);
   assign div_den = {1'b0, ref_ff, 1'b0};

   rpwm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpwm_pkg::ST_IDLE:
            if (!fifo_empty && rd_rec.frame_end) state_in = rpwm_pkg::ST_S_RD;
         rpwm_pkg::ST_S_RD:  state_in = rpwm_pkg::ST_S_CHK;
         rpwm_pkg::ST_S_CHK:
            if (found) state_in = rpwm_pkg::ST_M_RD;
            else if (k_last) state_in = rpwm_pkg::ST_OUT;
            else state_in = rpwm_pkg::ST_S_RD;
         rpwm_pkg::ST_M_RD:  state_in = rpwm_pkg::ST_M_CHK;
         rpwm_pkg::ST_M_CHK:
            if (({2'b0, k_ff} + 13'd1) < end_ff) state_in = rpwm_pkg::ST_M_RD;
            else state_in = rpwm_pkg::ST_R_RD;
         rpwm_pkg::ST_R_RD:  state_in = rpwm_pkg::ST_R_CHK;
         rpwm_pkg::ST_R_CHK:
            if (rd_data_ff == '0) state_in = rpwm_pkg::ST_OUT;
            else state_in = rpwm_pkg::ST_MUL;
         rpwm_pkg::ST_MUL:    state_in = rpwm_pkg::ST_DIV_GO;
         rpwm_pkg::ST_DIV_GO: state_in = rpwm_pkg::ST_DIV_WAIT;
         rpwm_pkg::ST_DIV_WAIT:
            if (div_done) state_in = rpwm_pkg::ST_OUT;
         rpwm_pkg::ST_OUT:
            if (rsp_chan.ready) state_in = rpwm_pkg::ST_IDLE;
         default: state_in = rpwm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pop        = 1'b0;
      mem_we     = 1'b0;
      div_go     = 1'b0;
      row_idx_in = row_idx_ff;
      h_in       = h_ff;
      k_in       = k_ff;
      start_in   = start_ff;
      widest_in  = widest_ff;
      min_in     = min_ff;
      ref_in     = ref_ff;
      end_in     = end_ff;
      diff_in    = diff_ff;
      num_in     = num_ff;
      neg_in     = neg_ff;
      win_in     = win_ff;
      res_width_in  = res_width_ff;
      res_start_in  = res_start_ff;
      res_widest_in = res_widest_ff;
      res_status_in = res_status_ff;
      case (state_ff)
         rpwm_pkg::ST_IDLE: begin
            if (!fifo_empty) begin
               pop = 1'b1;
               h_in = row_idx_ff;
               if (row_idx_ff != CW'(rpwm_pkg::ROWS)) begin
                  mem_we = 1'b1;
                  row_idx_in = row_idx_ff + 1'b1;
                  h_in = row_idx_ff + 1'b1;
               end
               if (rd_rec.frame_end) begin
                  row_idx_in = '0;
                  k_in = '0;
               end
            end
         end
         rpwm_pkg::ST_S_CHK: begin
            win_in[0] = rd_data_ff;
            win_in[1] = win_ff[0];
            win_in[2] = win_ff[1];
            win_in[3] = win_ff[2];
            if (found) begin
               start_in = k_ff - AW'(2);
               k_in     = k_ff - AW'(2);
               min_in   = rpwm_pkg::CNT_MAX;
               end_in   = ({2'b0, k_ff} - 13'd2) + {1'b0, search_ff};
               if (end_in > {1'b0, h_ff}) end_in = {1'b0, h_ff};
            end else if (k_last) begin
               res_width_in  = '0;
               res_start_in  = '0;
               res_widest_in = '0;
               res_status_in = rpwm_pkg::STATUS_NO_START;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         rpwm_pkg::ST_M_CHK: begin
            // keep the last row holding the minimum
            if (rd_data_ff <= min_ff) begin
               min_in    = rd_data_ff;
               widest_in = k_ff;
            end
            if (({2'b0, k_ff} + 13'd1) < end_ff) begin
               k_in = k_ff + 1'b1;
            end else if ({5'b0, refofs_ff} > start_ff) begin
               k_in = '0;
            end else begin
               k_in = start_ff - AW'(refofs_ff);
            end
         end
         rpwm_pkg::ST_R_CHK: begin
            ref_in  = rd_data_ff;
            diff_in = $signed({1'b0, rd_data_ff}) - $signed({1'b0, min_ff});
            res_start_in  = 11'(start_ff);
            res_widest_in = 11'(widest_ff);
            if (rd_data_ff == '0) begin
               res_width_in  = '0;
               res_status_in = rpwm_pkg::STATUS_ZERO_REF;
            end
         end
         rpwm_pkg::ST_MUL: begin
            num_in = rpwm_pkg::NUM_W'(diff_ff)
                   * rpwm_pkg::NUM_W'($signed({1'b0, span_ff}));
         end
         rpwm_pkg::ST_DIV_GO: begin
            div_go = 1'b1;
            neg_in = num_ff[rpwm_pkg::NUM_W-1];
         end
         rpwm_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               res_status_in = rpwm_pkg::STATUS_OK;
               if (!neg_ff) begin
                  res_width_in = (div_quo > 31'd32767) ? 16'sh7FFF
                                                       : $signed(div_quo[15:0]);
               end else begin
                  res_width_in = (div_quo > 31'd32768) ? 16'sh8000
                                                       : $signed(-div_quo[15:0]);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      h_ff      <= h_in;
      k_ff      <= k_in;
      start_ff  <= start_in;
      widest_ff <= widest_in;
      min_ff    <= min_in;
      ref_ff    <= ref_in;
      end_ff    <= end_in;
      diff_ff   <= diff_in;
      num_ff    <= num_in;
      neg_ff    <= neg_in;
      win_ff    <= win_in;
      res_width_ff  <= res_width_in;
      res_start_ff  <= res_start_in;
      res_widest_ff <= res_widest_in;
      res_status_ff <= res_status_in;
      if (reset) begin
         state_ff   <= rpwm_pkg::ST_IDLE;
         row_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         row_idx_ff <= row_idx_in;
      end
   end

   assign rsp_chan.valid        = state_ff == rpwm_pkg::ST_OUT;
   assign rsp_chan.width_tenths = res_width_ff;
   assign rsp_chan.start_row    = res_start_ff;
   assign rsp_chan.widest_row   = res_widest_ff;
   assign rsp_chan.status       = res_status_ff;

endmodule

### src/row_profile_width_meter_core.sv
// channel    dir  payload                                     transfer when
// req_chan   in   foreground, row_end, frame_end              valid & ready
// rsp_chan   out  width_tenths, start_row, widest_row, status valid & ready
// csr_chan   in   index, data                                 valid & ready
//
// Pixels are taken one per cycle; each finished row goes through a four-entry
// queue into the profile memory. At frame end the analysis walks the memory
// through its single read port, with a read state and a check state per row:
// the start search, the minimum over up to search_rows rows, the reference row,
// the multiply and the bit-serial divider. Input stalls only when the queue
// fills during analysis. Reset is synchronous; the profile memory is not cleared.
module row_profile_width_meter_core (
   input  logic        clock,
   input  logic        reset,
   rpwm_req_if.sink    req_chan,
   rpwm_rsp_if.source  rsp_chan,
   rpwm_csr_if.sink    csr_chan
);

   rpwm_pkg::fifo_wr_type fifo_wr;
   rpwm_pkg::row_rec_type rd_rec;
   logic                  fifo_full, fifo_empty, pop;

   rpwm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .fifo_full (fifo_full),
      .fifo_wr   (fifo_wr)
   );

   rpwm_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .fifo_wr (fifo_wr),
      .pop     (pop),
      .rd_rec  (rd_rec),
      .full    (fifo_full),
      .empty   (fifo_empty)
   );

   rpwm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .rd_rec     (rd_rec),
      .fifo_empty (fifo_empty),
      .pop        (pop),
      .rsp_chan   (rsp_chan),
      .csr_chan   (csr_chan)
   );

endmodule
